@@ design/b2a_pkg.sv @@
// ----------------------------------------------------------------------------
// b2a_pkg
// Shared types, constants and helpers for the binary to ASCII digit converter.
// ----------------------------------------------------------------------------
package b2a_pkg;

  localparam int unsigned DigitSlots = 10;
  localparam int unsigned CntW       = $clog2(DigitSlots + 1);
  localparam int unsigned IdxW       = $clog2(DigitSlots);

  // floor(x / 10) == (x * DivMagic) >> DivShift for every 32-bit x
  localparam logic [31:0] DivMagic = 32'hCCCC_CCCD;
  localparam int unsigned DivShift = 35;
  localparam int unsigned QuotW    = 64 - DivShift;

  localparam logic [6:0] AsciiZero = 7'h30;
  localparam logic [6:0] AsciiA    = 7'h61;
  localparam logic [3:0] DecRadix  = 4'd10;

  typedef logic [3:0] digit_t;

  typedef struct packed {
    logic [31:0] quot;
    digit_t      rem;
  } div_res_t;

  function automatic logic [6:0] digit_code(input digit_t d);
    logic [6:0] code;
    if (d < DecRadix) begin
      code = AsciiZero + {3'b000, d};
    end else begin
      code = AsciiA + {3'b000, d - DecRadix};
    end
    return code;
  endfunction

endpackage

@@ design/b2a_div_unit.sv @@
// ----------------------------------------------------------------------------
// b2a_div_unit
// Divides a 32-bit word by 10 or 16 and returns quotient and remainder in the
// cycle after the operand is presented. Decimal uses a reciprocal multiply.
// ----------------------------------------------------------------------------
module b2a_div_unit import b2a_pkg::*; (
  input  logic        clk,
  input  logic [31:0] dividend,
  input  logic        hex,
  output div_res_t    res
);

  logic [63:0] prod;
  logic [31:0] dividend_q;
  logic        hex_q;
  logic [31:0] quot_dec;
  logic [31:0] times_ten;
  logic [31:0] rem_dec;

  always_ff @(posedge clk) begin
    prod       <= {32'd0, dividend} * {32'd0, DivMagic};
    dividend_q <= dividend;
    hex_q      <= hex;
  end

  always_comb begin
    quot_dec  = {{(32 - QuotW){1'b0}}, prod[63:DivShift]};
    times_ten = {quot_dec[28:0], 3'b000} + {quot_dec[30:0], 1'b0};
    rem_dec   = dividend_q - times_ten;
    if (hex_q) begin
      res.quot = {4'd0, dividend_q[31:4]};
      res.rem  = dividend_q[3:0];
    end else begin
      res.quot = quot_dec;
      res.rem  = rem_dec[3:0];
    end
  end

endmodule

@@ design/binary_to_ascii_digits.sv @@
// ----------------------------------------------------------------------------
// binary_to_ascii_digits
// Converts a 32-bit unsigned word to ASCII decimal or lower-case hex digits,
// most significant first, leading zeros dropped, last flag on the final digit.
// ----------------------------------------------------------------------------
//  channel   ports                         handshake
//  input     op, value                     start && !busy
//  result    digit_char, last              strobe (one cycle, no backpressure)
//
//  Each digit passes through the shared divide unit in S_LOAD (registered
//  multiply) and S_STORE (remainder stored); the digits are then driven one
//  per cycle on the result port. A decimal word has 1..10 digits, hex 1..8.
//  busy is high from accept until the last digit is driven. rst clears the
//  sequencer and strobe; the digit buffer needs no reset.
// ----------------------------------------------------------------------------
module binary_to_ascii_digits import b2a_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [31:0] value,
  output logic        strobe,
  output logic [6:0]  digit_char,
  output logic        last
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_STORE,
    S_EMIT
  } state_t;

  state_t          state;
  logic [31:0]     num;
  logic            hex;
  logic [CntW-1:0] cnt;
  logic [IdxW-1:0] idx;
  digit_t          digits [DigitSlots];
  div_res_t        div_res;

  b2a_div_unit u_div (
    .clk      (clk),
    .dividend (num),
    .hex      (hex),
    .res      (div_res)
  );

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
      cnt    <= '0;
      idx    <= '0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            num   <= value;
            hex   <= op;
            cnt   <= '0;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          // divide unit registers num this cycle
          state <= S_STORE;
        end
        S_STORE: begin
          digits[cnt[IdxW-1:0]] <= div_res.rem;
          num <= div_res.quot;
          cnt <= cnt + 1'b1;
          if (div_res.quot == 32'd0 || cnt == CntW'(DigitSlots - 1)) begin
            idx   <= cnt[IdxW-1:0];
            state <= S_EMIT;
          end else begin
            state <= S_LOAD;
          end
        end
        S_EMIT: begin
          strobe     <= 1'b1;
          digit_char <= digit_code(digits[idx]);
          last       <= (idx == '0);
          if (idx == '0) begin
            state <= S_IDLE;
          end else begin
            idx <= idx - 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for binary_to_ascii_digits. Directed words cover zero,
// the all-ones and top-bit patterns, and the digit-count and letter
// boundaries. Random words follow, sent in bursts with random gaps. Every
// digit on the result port is compared with the expected text of a directed
// word or with a local decimal/hex digit predictor.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import b2a_pkg::*;

  localparam logic OpDec = 1'b0;
  localparam logic OpHex = 1'b1;
  localparam int   RandomWords = 480;
  localparam int   TailCycles = 40;
  localparam int   DrainLimit = 2000;

  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } digit_word_t;

  // text is the digit string expected; empty means use the predictor
  typedef struct {
    logic        op;
    logic [31:0] value;
    string       text;
  } word_case_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        op = OpDec;
  logic [31:0] value = '0;
  logic        busy;
  logic        strobe;
  logic [6:0]  digit_char;
  logic        last;

  digit_word_t pending_digits[$];
  int          errors = 0;
  int          words_sent = 0;
  int          hex_words = 0;
  int          digits_checked = 0;
  int          longest_run = 0;

  word_case_t directed_words[22] = '{
    '{OpDec, 32'd0,          "0"},
    '{OpHex, 32'd0,          "0"},
    '{OpDec, 32'hFFFF_FFFF,  "4294967295"},
    '{OpHex, 32'hFFFF_FFFF,  "ffffffff"},
    '{OpDec, 32'h8000_0000,  "2147483648"},
    '{OpHex, 32'h8000_0000,  "80000000"},
    '{OpDec, 32'h7FFF_FFFF,  "2147483647"},
    '{OpDec, 32'd1,          "1"},
    '{OpHex, 32'd1,          "1"},
    '{OpDec, 32'd9,          "9"},
    '{OpDec, 32'd10,         "10"},
    '{OpHex, 32'd9,          "9"},
    '{OpHex, 32'd10,         "a"},
    '{OpHex, 32'd15,         "f"},
    '{OpHex, 32'd16,         "10"},
    '{OpHex, 32'hABCD_EF01,  "abcdef01"},
    '{OpHex, 32'h0FFF_FFFF,  "fffffff"},
    '{OpDec, 32'd999999999,  "999999999"},
    '{OpDec, 32'd1000000000, "1000000000"},
    '{OpDec, 32'hAAAA_AAAA,  ""},
    '{OpHex, 32'h5555_5555,  ""},
    '{OpDec, 32'd12345,      ""}
  };

  binary_to_ascii_digits u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .value      (value),
    .strobe     (strobe),
    .digit_char (digit_char),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL binary_to_ascii_digits");
    $finish;
  end

  task automatic note_mismatch(input string msg);
    errors++;
    if (errors <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // digits of one word, least significant found first, queued msb first
  function automatic void queue_conversion(input logic w_op, input logic [31:0] w_val);
    digit_word_t run[$];
    logic [31:0] rest;
    logic [31:0] radix;
    logic [3:0]  d;
    rest = w_val;
    radix = (w_op == OpHex) ? 32'd16 : 32'd10;
    do begin
      d = 4'(rest % radix);
      if (d < 4'd10) begin
        run.push_front('{code: AsciiZero + 7'(d), last: 1'b0});
      end else begin
        run.push_front('{code: AsciiA + 7'(d - 4'd10), last: 1'b0});
      end
      rest = rest / radix;
    end while (rest != 0);
    run[run.size() - 1].last = 1'b1;
    if (run.size() > longest_run) longest_run = run.size();
    foreach (run[i]) pending_digits.push_back(run[i]);
  endfunction

  task automatic send_word(input logic w_op, input logic [31:0] w_val, input string text);
    start <= 1'b1;
    op <= w_op;
    value <= w_val;
    do @(posedge clk); while (busy);
    words_sent++;
    if (w_op == OpHex) hex_words++;
    if (text == "") begin
      queue_conversion(w_op, w_val);
    end else begin
      for (int i = 0; i < text.len(); i++) begin
        pending_digits.push_back('{code: 7'(text[i]), last: (i == text.len() - 1)});
      end
      if (text.len() > longest_run) longest_run = text.len();
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
  endtask

  // result port: sampled at the edge that ends the strobe cycle
  always @(posedge clk) begin
    digit_word_t want;
    if (!rst && strobe) begin
      digits_checked++;
      if (pending_digits.size() == 0) begin
        note_mismatch($sformatf("unexpected digit 0x%02h last=%0b", digit_char, last));
      end else begin
        want = pending_digits.pop_front();
        if (digit_char !== want.code || last !== want.last) begin
          note_mismatch($sformatf("digit exp 0x%02h last=%0b, got 0x%02h last=%0b",
                                  want.code, want.last, digit_char, last));
        end
      end
    end
  end

  initial begin
    int          burst_left;
    int          gap;
    int          drain_cycles;
    logic        r_op;
    logic [31:0] r_val;
    logic [31:0] pw;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_words[i]) begin
      send_word(directed_words[i].op, directed_words[i].value, directed_words[i].text);
      if ($urandom_range(0, 2) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
    drain();

    burst_left = 0;
    for (int n = 0; n < RandomWords; n++) begin
      if (n == RandomWords / 2) drain();
      r_op = $urandom_range(0, 1);
      case ($urandom_range(0, 6))
        0, 1: r_val = $urandom;
        2, 3: r_val = $urandom >> $urandom_range(0, 31);
        4: begin
          // around a power of the radix, where the digit count changes
          pw = 32'd1;
          repeat ($urandom_range(1, (r_op == OpHex) ? 7 : 9))
            pw = pw * ((r_op == OpHex) ? 32'd16 : 32'd10);
          r_val = pw + $urandom_range(0, 2) - 1;
        end
        5: r_val = $urandom_range(0, 20);
        default: r_val = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0;
      endcase
      send_word(r_op, r_val, "");
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end else begin
        burst_left--;
      end
    end

    start <= 1'b0;
    drain_cycles = 0;
    while (pending_digits.size() != 0 && drain_cycles < DrainLimit) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (TailCycles) @(posedge clk);
    if (pending_digits.size() != 0) begin
      note_mismatch($sformatf("%0d digits never arrived", pending_digits.size()));
    end

    $display("Converted %0d words (%0d decimal, %0d hex), longest run %0d digits",
             words_sent, words_sent - hex_words, hex_words, longest_run);
    $display("Checked %0d digits, %0d mismatches", digits_checked, errors);
    if (errors == 0) begin
      $display("PASS binary_to_ascii_digits");
    end else begin
      $display("FAIL binary_to_ascii_digits");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/b2a_pkg.sv
design/b2a_div_unit.sv
design/binary_to_ascii_digits.sv
bench/testbench.sv
